### hdl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg
// Types, constants and capacity helpers shared by the resizing LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

package rls_pkg;

  // Field widths fixed by the interface
  localparam int WORD_W = 32;
  localparam int CFG_W  = 11;
  localparam int CNT_W  = 11;
  localparam int CAP_W  = 16;
  localparam int RSZ_W  = 32;

  // Operation codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Capacity bookkeeping constants
  localparam logic [CAP_W-1:0]  MIN_CAP    = 16'd10;
  localparam logic [CAP_W-1:0]  CAP_MAX    = 16'hFFFF;
  localparam logic [CAP_W-1:0]  CAP_RESET  = 16'd10;
  localparam logic [WORD_W-1:0] EMPTY_WORD = 32'h7FFF_FFFF;

  // One request: push or pop
  typedef struct packed {
    logic                     action;
    logic signed [WORD_W-1:0] push_value;
  } rls_req_t;

  // One result
  typedef struct packed {
    logic signed [WORD_W-1:0] pop_value;
    logic                     empty_error;
    logic                     overflow_error;
    logic [CNT_W-1:0]         element_count;
    logic [CAP_W-1:0]         current_capacity;
    logic [CAP_W-1:0]         peak_capacity;
    logic [RSZ_W-1:0]         resize_total;
  } rls_rsp_t;

  // Double, saturating at the top of the range
  function automatic logic [CAP_W-1:0] grow_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W:0] dbl;
    dbl = {c, 1'b0};
    return dbl[CAP_W] ? CAP_MAX : dbl[CAP_W-1:0];
  endfunction

  // Halve, clamped at the floor
  function automatic logic [CAP_W-1:0] shrink_cap(input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] half;
    half = c >> 1;
    return (half <= MIN_CAP) ? MIN_CAP : half;
  endfunction

endpackage

`default_nettype wire

### hdl/rls_ram.sv
// ----------------------------------------------------------------------------
// rls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/resizing_lifo_stack.sv
// ----------------------------------------------------------------------------
// resizing_lifo_stack
// LIFO of signed 32-bit words with logical capacity bookkeeping.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the request is taken at any
//   edge where start is high and busy is low. busy stays low, so a push or
//   pop can be issued every cycle.
//   Result channel: done pulses for one cycle in the cycle after each
//   request is taken, with rsp valid in that cycle. Throughput is 1
//   request per cycle; the pop word comes straight from the registered
//   read port of the stack memory, the rest from the state regs.
//   The receiver cannot stall; results must be captured when done is high.
//   Config channel: cfg_data loads the capacity register (0 loads 1);
//   cfg_ready is always high. Write only when no result is outstanding.
//   Reset (rst, synchronous): empty stack, capacity 10, peak 10, resize
//   count 0. Memory contents are not cleared; only written entries are read,
//   so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module resizing_lifo_stack
  import rls_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rls_req_t         req,
  output logic             done,
  output rls_rsp_t         rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int MW = ((CW > CAP_W) ? CW : CAP_W) + 3;

  // State
  logic [CW-1:0]    count, count_next;
  logic [CAP_W-1:0] cap, cap_next;
  logic [CAP_W-1:0] peak, peak_next;
  logic [RSZ_W-1:0] resize_cnt, resize_cnt_next;

  // Result stage
  logic out_empty, out_over, out_pop_ok;

  logic             accept, cfg_wr;
  logic             full;
  logic [CW-1:0]    cnt_inc, cnt_dec;
  logic             grow1, grow2, ev1, ev2, shrink;
  logic [CAP_W-1:0] cap_a, cap_b, cap_s;
  logic [MW-1:0]    dec6;
  logic [1:0]       ev_num;
  logic [RSZ_W:0]   rsum;
  logic             empty_flag, over_flag;
  logic             ram_we, ram_re;
  logic [WORD_W-1:0] ram_rdata;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Push path: possible grow before and after the store
  assign full    = (count == CW'(DEPTH));
  assign cnt_inc = count + 1'b1;
  assign cnt_dec = count - 1'b1;
  assign grow1   = MW'(count) >= MW'(cap);
  assign cap_a   = grow1 ? grow_cap(cap) : cap;
  assign ev1     = (cap_a != cap);
  assign grow2   = MW'(cnt_inc) >= MW'(cap_a);
  assign cap_b   = grow2 ? grow_cap(cap_a) : cap_a;
  assign ev2     = (cap_b != cap_a);

  // Pop path: shrink when remaining count <= cap/6, i.e. 6*count <= cap, and cap is above MIN_CAP
  assign dec6   = (MW'(cnt_dec) << 2) + (MW'(cnt_dec) << 1);
  assign shrink = (dec6 <= MW'(cap)) && (cap > MIN_CAP);
  assign cap_s  = shrink_cap(cap);

  // Next-state decode
  always_comb begin
    count_next = count;
    cap_next   = cap;
    peak_next  = peak;
    ev_num     = 2'd0;
    empty_flag = 1'b0;
    over_flag  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (accept) begin
      if (req.action == ACT_PUSH) begin
        if (full) begin
          over_flag = 1'b1;
        end else begin
          ram_we     = 1'b1;
          count_next = cnt_inc;
          cap_next   = cap_b;
          ev_num     = {1'b0, ev1} + {1'b0, ev2};
          if ((ev1 || ev2) && (cap_b > peak)) begin
            peak_next = cap_b;
          end
        end
      end else begin
        if (count == '0) begin
          empty_flag = 1'b1;
        end else begin
          ram_re     = 1'b1;
          count_next = cnt_dec;
          if (shrink) begin
            cap_next = cap_s;
            ev_num   = 2'd1;
          end
        end
      end
    end
  end

  // Saturating resize count
  assign rsum            = {1'b0, resize_cnt} + (RSZ_W + 1)'(ev_num);
  assign resize_cnt_next = rsum[RSZ_W] ? '1 : rsum[RSZ_W-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      cap        <= CAP_RESET;
      peak       <= MIN_CAP;
      resize_cnt <= '0;
      done       <= 1'b0;
    end else begin
      done <= accept;
      if (cfg_wr) begin
        cap <= (cfg_data == '0) ? CAP_W'(1) : CAP_W'(cfg_data);
      end else begin
        count      <= count_next;
        cap        <= cap_next;
        peak       <= peak_next;
        resize_cnt <= resize_cnt_next;
      end
    end
  end

  // Result flags
  always_ff @(posedge clk) begin
    out_empty  <= empty_flag;
    out_over   <= over_flag;
    out_pop_ok <= ram_re;
  end

  // Stack memory: push writes at count, pop reads at count-1
  rls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (req.push_value),
    .re    (ram_re),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result assembly: counts come from state updated by this request
  always_comb begin
    rsp.pop_value        = out_pop_ok ? ram_rdata : (out_empty ? EMPTY_WORD : '0);
    rsp.empty_error      = out_empty;
    rsp.overflow_error   = out_over;
    rsp.element_count    = CNT_W'(count);
    rsp.current_capacity = cap;
    rsp.peak_capacity    = peak;
    rsp.resize_total     = resize_cnt;
  end

`ifndef SYNTHESIS
  // Exactly one result per accepted request, in the next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("result missing after request");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done) else $error("result without request");
  // Fill level bounded by the memory
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    MW'(count) <= MW'(DEPTH)) else $error("element count beyond depth");
  // Error flags are exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.empty_error && rsp.overflow_error))
    else $error("empty and overflow together");
  // Capacity never zero, peak never below floor
  a_cap_sane: assert property (@(posedge clk) disable iff (rst)
    (cap != '0) && (peak >= MIN_CAP)) else $error("capacity bookkeeping broken");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the resizing LIFO stack. Push and pop requests are
// driven in random bursts; a scoreboard class keeps its own copy of the stack
// and of the capacity bookkeeping, predicts each result and compares it
// field by field with what the block returns in the cycle after.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rls_pkg::*;

  localparam int          STACK_DEPTH = 1024;
  localparam int          CLK_PERIOD  = 10;
  localparam int          RESET_LEN   = 9;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DRAIN_WAIT  = 4;
  localparam int unsigned SHRINK_DIV  = 6;
  localparam int unsigned CFG_RESET   = 10;

  // Scoreboard: mirror of stack and capacity state, queue of expected results
  class rls_scoreboard;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int unsigned       stack_fill;
    int unsigned       capacity;
    int unsigned       peak;
    logic [RSZ_W-1:0]  resizes;
    rls_rsp_t          expected_q [$];
    int unsigned       errors;

    function new();
      stack_fill = 0;
      capacity   = CFG_RESET;
      peak       = MIN_CAP;
      resizes    = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Register write: a zero is taken as one
    function void load_capacity(logic [CFG_W-1:0] v);
      capacity = (v == '0) ? 1 : int'(v);
    endfunction

    function void count_resize();
      if (resizes != '1) resizes++;
    endfunction

    // Grow event: doubles, saturating; no event once saturated
    function void double_capacity();
      int unsigned nc;
      nc = capacity * 2;
      if (nc > CAP_MAX) nc = CAP_MAX;
      if (nc == capacity) return;
      capacity = nc;
      if (nc > peak) peak = nc;
      count_resize();
    endfunction

    // Shrink event: halves, floored at the minimum
    function void halve_capacity();
      int unsigned nc;
      if (capacity <= MIN_CAP) return;
      nc = capacity / 2;
      if (nc <= MIN_CAP) nc = MIN_CAP;
      capacity = nc;
      count_resize();
    endfunction

    // Accepted request: update the mirror and queue the expected result
    function void note_request(rls_req_t r);
      rls_rsp_t e;
      e = '0;
      if (r.action == ACT_PUSH) begin
        if (stack_fill >= STACK_DEPTH) begin
          e.overflow_error = 1'b1;
        end else begin
          // a push at or above capacity grows before the store too
          if (stack_fill >= capacity) double_capacity();
          words[stack_fill] = r.push_value;
          stack_fill++;
          if (stack_fill >= capacity) double_capacity();
        end
      end else begin
        if (stack_fill == 0) begin
          e.pop_value   = EMPTY_WORD;
          e.empty_error = 1'b1;
        end else begin
          stack_fill--;
          e.pop_value = words[stack_fill];
          if (stack_fill <= capacity / SHRINK_DIV) halve_capacity();
        end
      end
      e.element_count    = CNT_W'(stack_fill);
      e.current_capacity = CAP_W'(capacity);
      e.peak_capacity    = CAP_W'(peak);
      e.resize_total     = resizes;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(rls_rsp_t got);
      rls_rsp_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("pop_value", e.pop_value, got.pop_value);
      compare_field("empty_error", 32'(e.empty_error), 32'(got.empty_error));
      compare_field("overflow_error", 32'(e.overflow_error), 32'(got.overflow_error));
      compare_field("element_count", 32'(e.element_count), 32'(got.element_count));
      compare_field("current_capacity", 32'(e.current_capacity),
                    32'(got.current_capacity));
      compare_field("peak_capacity", 32'(e.peak_capacity), 32'(got.peak_capacity));
      compare_field("resize_total", e.resize_total, got.resize_total);
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  rls_req_t         req       = '0;
  logic             done;
  rls_rsp_t         rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  rls_scoreboard sb;
  int unsigned   cycle_count = 0;
  int            burst_left  = 8;

  resizing_lifo_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .done     (done),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result monitor: done is a one-cycle strobe, no back-pressure
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(rsp);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("resizing_lifo_stack verification failed");
      $finish;
    end
  end

  // Word biased towards the signed extremes and simple patterns
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] edge_word(int i);
    case (i)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4:       return 32'h5555_5555;
      5:       return 32'hAAAA_AAAA;
      6:       return 32'h0000_0001;
      7:       return 32'hFFFF_FFFE;
      default: return $urandom();
    endcase
  endfunction

  // Drop start and idle; an argument of zero does nothing
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Sender pacing: bursts of random length, occasionally long ones
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      idle_cycles($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
  endtask

  // One request: hold start until it is taken, then note it
  task automatic drive_request(input logic act, input logic [WORD_W-1:0] w);
    rls_req_t r;
    r.action     = act;
    r.push_value = w;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    pace_sender();
  endtask

  // Wait until every expected result is back, plus a DRAIN_WAIT margin
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Capacity register write, only with the block idle
  task automatic write_capacity(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_capacity(v);
  endtask

  // Random mix with a given share of pushes
  task automatic run_mix(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      drive_request(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP,
                    random_word());
    end
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_list [8];
    int               mix_pct  [3];
    int               to_fill;

    sb = new();
    cfg_list = '{11'd1024, 11'd2047, 11'd10, 11'd1, 11'd0, 11'd3, 11'h555, 11'h2AA};
    mix_pct  = '{70, 50, 30};

    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty pop, grow at capacity, shrink on drain, double grow
    drive_request(ACT_POP, '1);
    for (int i = 0; i < 10; i++) drive_request(ACT_PUSH, edge_word(i));
    for (int i = 0; i < 11; i++) drive_request(ACT_POP, $urandom());
    for (int i = 0; i < 3; i++) drive_request(ACT_PUSH, edge_word(i + 3));
    write_capacity('0);
    drive_request(ACT_PUSH, edge_word(4));

    // Random phases across register settings
    for (int p = 0; p < 8; p++) begin
      if (p == 4) write_capacity(CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
      else write_capacity(cfg_list[p]);
      run_mix(16, mix_pct[p % 3]);
    end

    // Fill the memory to overflow, then pop a stretch off the top
    write_capacity(11'd1);
    to_fill = STACK_DEPTH - int'(sb.stack_fill) + 3;
    for (int i = 0; i < to_fill; i++) drive_request(ACT_PUSH, random_word());
    drive_request(ACT_POP, '0);
    drive_request(ACT_PUSH, random_word());
    drive_request(ACT_PUSH, random_word());
    for (int i = 0; i < 30; i++) drive_request(ACT_POP, random_word());

    // Back to a mid setting with a light mix
    write_capacity(11'd40);
    run_mix(40, 60);

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("resizing_lifo_stack verification clean");
    end else begin
      $display("resizing_lifo_stack verification failed");
    end
    $finish;
  end

endmodule
